// File: src/ors_pkg.sv
// ----------------------------------------------------------------------------
// ors_pkg
// Shared types, codes and helpers for the 1-Wire ROM search decision engine.
// ----------------------------------------------------------------------------
package ors_pkg;

    // number of bits in one device ROM
    localparam int unsigned RomBits = 64;
    localparam int unsigned PosW    = 7;
    localparam int unsigned ShW     = 6;
    localparam logic [7:0]  CrcPoly = 8'h8C;

    // request opcodes
    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_PRESENCE = 2'd1,
        OP_BIT_PAIR = 2'd2,
        OP_RESERVED = 2'd3
    } opcode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_PRESENCE  = 2'd1,
        ST_NO_RESPONDER = 2'd2,
        ST_IGNORED      = 2'd3
    } status_t;

    // scan phases
    typedef enum logic [1:0] {
        PHASE_IDLE     = 2'd0,
        PHASE_PRESENCE = 2'd1,
        PHASE_BITS     = 2'd2
    } phase_t;

    // one request as held in the input register
    typedef struct packed {
        logic [1:0] opcode;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } item_t;

    // one result as held in the result register
    typedef struct packed {
        logic        write_bit;
        logic        write_valid;
        logic        pass_end;
        logic        rom_valid;
        logic [63:0] rom_code;
        logic        scan_end;
        logic        scan_success;
        logic [1:0]  status;
        logic [1:0]  found_devices;
    } result_t;

    // handshake between the stages
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

    // one step of the reflected Dallas CRC8
    function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic b);
        logic [7:0] shifted;
        shifted = {1'b0, crc[7:1]};
        return (crc[0] ^ b) ? (shifted ^ CrcPoly) : shifted;
    endfunction

endpackage

// File: src/ors_if.sv
// ----------------------------------------------------------------------------
// ors_if
// Valid/ready channels for search requests and search results.
// ----------------------------------------------------------------------------
interface ors_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;

    modport source (output valid, output opcode, output presence, output id_bit,
                    output complement_bit, input ready);
    modport sink   (input valid, input opcode, input presence, input id_bit,
                    input complement_bit, output ready);
endinterface

interface ors_rsp_if;
    logic        valid;
    logic        ready;
    logic        write_bit;
    logic        write_valid;
    logic        pass_end;
    logic        rom_valid;
    logic [63:0] rom_code;
    logic        scan_end;
    logic        scan_success;
    logic [1:0]  status;
    logic [1:0]  found_devices;

    modport source (output valid, output write_bit, output write_valid, output pass_end,
                    output rom_valid, output rom_code, output scan_end,
                    output scan_success, output status, output found_devices,
                    input ready);
    modport sink   (input valid, input write_bit, input write_valid, input pass_end,
                    input rom_valid, input rom_code, input scan_end,
                    input scan_success, input status, input found_devices,
                    output ready);
endinterface

// File: src/ors_in_stage.sv
// ----------------------------------------------------------------------------
// ors_in_stage
// Input register: holds one request until the engine consumes it.
// ----------------------------------------------------------------------------
module ors_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  ors_pkg::item_t  item_in,
    output ors_pkg::hs_t    up_hs,
    input  logic            up_valid,
    output logic            hold_valid,
    output ors_pkg::item_t  hold_item
);

    logic           valid_reg;
    logic           valid_next;
    ors_pkg::item_t item_reg;
    logic           load;

    // free slot or slot drained this cycle
    always_comb
    begin
        up_hs.valid = up_valid;
        up_hs.ready = !valid_reg || take;
        load        = up_valid && up_hs.ready;
        valid_next  = load ? 1'b1 : (take ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

// File: src/ors_engine.sv
// ----------------------------------------------------------------------------
// ors_engine
// Search state and the single-step decision logic for one request.
// ----------------------------------------------------------------------------
module ors_engine
#(
    parameter int unsigned DEVICE_LIMIT = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ors_pkg::item_t   item,
    output ors_pkg::result_t res
);

    ors_pkg::phase_t                 phase_reg, phase_next;
    logic [ors_pkg::RomBits-1:0]     rom_reg, rom_next;
    logic [ors_pkg::PosW-1:0]        last_reg, last_next;
    logic [ors_pkg::PosW-1:0]        pconf_reg, pconf_next;
    logic [ors_pkg::PosW-1:0]        pos_reg, pos_next;
    logic [7:0]                      crc_reg, crc_next;
    logic [1:0]                      tally_reg, tally_next;

    logic [ors_pkg::ShW-1:0]         sh;
    logic                            dir;
    logic                            ok;

    // next state and result for the request in the input register
    always_comb
    begin
        phase_next = phase_reg;
        rom_next   = rom_reg;
        last_next  = last_reg;
        pconf_next = pconf_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        tally_next = tally_reg;
        res        = '0;
        sh         = pos_reg[ors_pkg::ShW-1:0] - ors_pkg::ShW'(1);
        dir        = 1'b0;
        ok         = 1'b0;

        if (item.opcode == ors_pkg::OP_START)
        begin
            rom_next   = '0;
            last_next  = '0;
            pconf_next = '0;
            pos_next   = ors_pkg::PosW'(1);
            crc_next   = '0;
            tally_next = '0;
            phase_next = ors_pkg::PHASE_PRESENCE;
        end
        else if (item.opcode == ors_pkg::OP_PRESENCE && phase_reg == ors_pkg::PHASE_PRESENCE)
        begin
            if (!item.presence)
            begin
                res.scan_end = 1'b1;
                res.status   = ors_pkg::ST_NO_PRESENCE;
                phase_next   = ors_pkg::PHASE_IDLE;
            end
            else
            begin
                pos_next   = ors_pkg::PosW'(1);
                pconf_next = '0;
                crc_next   = '0;
                phase_next = ors_pkg::PHASE_BITS;
            end
        end
        else if (item.opcode == ors_pkg::OP_BIT_PAIR && phase_reg == ors_pkg::PHASE_BITS)
        begin
            if (item.id_bit && item.complement_bit)
            begin
                res.scan_end = 1'b1;
                res.status   = ors_pkg::ST_NO_RESPONDER;
                phase_next   = ors_pkg::PHASE_IDLE;
            end
            else
            begin
                // direction from the pair, or resolve a discrepancy
                if (item.id_bit != item.complement_bit)
                begin
                    dir = item.id_bit;
                end
                else
                begin
                    if (pos_reg < last_reg)
                    begin
                        dir = rom_reg[sh];
                    end
                    else
                    begin
                        dir = (pos_reg == last_reg);
                    end
                    if (!dir)
                    begin
                        pconf_next = pos_reg;
                    end
                end
                rom_next[sh]    = dir;
                crc_next        = ors_pkg::crc_bit(crc_reg, dir);
                res.write_bit   = dir;
                res.write_valid = 1'b1;

                // end of pass: check, count, decide whether to go on
                if (pos_reg >= ors_pkg::PosW'(ors_pkg::RomBits))
                begin
                    ok            = (crc_next == 8'd0);
                    res.pass_end  = 1'b1;
                    res.rom_valid = ok;
                    res.rom_code  = rom_next;
                    if (ok && tally_reg != 2'd3)
                    begin
                        tally_next = tally_reg + 2'd1;
                    end
                    last_next = pconf_next;
                    if (pconf_next == '0 ||
                        {{(ors_pkg::PosW-2){1'b0}}, tally_next} >=
                        ors_pkg::PosW'(DEVICE_LIMIT))
                    begin
                        res.scan_end     = 1'b1;
                        res.scan_success = (tally_next != 2'd0);
                        phase_next       = ors_pkg::PHASE_IDLE;
                    end
                    else
                    begin
                        phase_next = ors_pkg::PHASE_PRESENCE;
                    end
                    pos_next = ors_pkg::PosW'(1);
                end
                else
                begin
                    pos_next = pos_reg + ors_pkg::PosW'(1);
                end
            end
        end
        else
        begin
            res.status = ors_pkg::ST_IGNORED;
        end

        res.found_devices = tally_next;
    end

    // search state, updated once per consumed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ors_pkg::PHASE_IDLE;
            rom_reg   <= '0;
            last_reg  <= '0;
            pconf_reg <= '0;
            pos_reg   <= ors_pkg::PosW'(1);
            crc_reg   <= '0;
            tally_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            rom_reg   <= rom_next;
            last_reg  <= last_next;
            pconf_reg <= pconf_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            tally_reg <= tally_next;
        end
    end

    // bit position stays within one ROM
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg >= ors_pkg::PosW'(1) && pos_reg <= ors_pkg::PosW'(ors_pkg::RomBits))
        else $error("bit position out of range");

    // a finished scan leaves the engine idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.scan_end |=> phase_reg == ors_pkg::PHASE_IDLE)
        else $error("scan ended but phase not idle");

    // a pass end always carries a direction bit
    a_pass_write: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.pass_end |-> res.write_valid && phase_reg == ors_pkg::PHASE_BITS)
        else $error("pass end without bit write");

    // tally only drops on a new scan
    a_tally_mono: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.opcode != ors_pkg::OP_START |=> tally_reg >= $past(tally_reg))
        else $error("device tally decreased");

endmodule

// File: src/ors_out_stage.sv
// ----------------------------------------------------------------------------
// ors_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module ors_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ors_pkg::result_t res_in,
    input  logic             down_ready,
    output logic             can_load,
    output logic             res_valid,
    output ors_pkg::result_t res_out
);

    logic             valid_reg;
    logic             valid_next;
    ors_pkg::result_t res_reg;

    // room when empty or when the held result leaves this cycle
    always_comb
    begin
        can_load   = !valid_reg || down_ready;
        valid_next = load ? 1'b1 : (down_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign res_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// File: src/onewire_rom_search.sv
// ----------------------------------------------------------------------------
// onewire_rom_search
// Decision engine for the 1-Wire Search ROM scan.
// ----------------------------------------------------------------------------
// Every request (start, presence report or bit-pair report) yields exactly one
// result. A request passes through an input register, one step of decision
// logic that also updates the search state, and a result register, so a
// result is presented on rsp once it has passed through both registers; one
// request can be accepted every cycle as long as results are taken, and
// cmd.ready follows rsp.ready through the two registers. The direction bit,
// ROM assembly and the bit-serial CRC8 for a bit pair are all resolved in
// that one step.
module onewire_rom_search
#(
    parameter int unsigned DEVICE_LIMIT = 2
)
(
    input logic         clk,
    input logic         rst_n,
    ors_cmd_if.sink     cmd,
    ors_rsp_if.source   rsp
);

    ors_pkg::item_t   item_in;
    ors_pkg::item_t   hold_item;
    ors_pkg::hs_t     up_hs;
    ors_pkg::result_t step_res;
    ors_pkg::result_t res_out;
    logic             hold_valid;
    logic             can_load;
    logic             step;

    // request payload into a struct
    always_comb
    begin
        item_in.opcode         = cmd.opcode;
        item_in.presence       = cmd.presence;
        item_in.id_bit         = cmd.id_bit;
        item_in.complement_bit = cmd.complement_bit;
    end

    assign step      = hold_valid && can_load;
    assign cmd.ready = up_hs.ready;

    // input register
    ors_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (step),
        .item_in    (item_in),
        .up_hs      (up_hs),
        .up_valid   (cmd.valid),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    // decision step and search state
    ors_engine #(.DEVICE_LIMIT(DEVICE_LIMIT)) u_engine
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (hold_item),
        .res   (step_res)
    );

    // result register
    ors_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .res_in     (step_res),
        .down_ready (rsp.ready),
        .can_load   (can_load),
        .res_valid  (rsp.valid),
        .res_out    (res_out)
    );

    // result struct onto the channel
    always_comb
    begin
        rsp.write_bit     = res_out.write_bit;
        rsp.write_valid   = res_out.write_valid;
        rsp.pass_end      = res_out.pass_end;
        rsp.rom_valid     = res_out.rom_valid;
        rsp.rom_code      = res_out.rom_code;
        rsp.scan_end      = res_out.scan_end;
        rsp.scan_success  = res_out.scan_success;
        rsp.status        = res_out.status;
        rsp.found_devices = res_out.found_devices;
    end

endmodule
